FILE: rtl/core/ilir_pkg.sv
`default_nettype none

package ilir_pkg;

    localparam int ILIR_CAPACITY = 32;

    typedef enum logic [2:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_READ   = 3'd3,
        ACT_POP    = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_INS_RD,
        S_INS_WR,
        S_CAP,
        S_REM_RD,
        S_REM_WR,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_IDX,
        RD_PTR_M1,
        RD_PTR_P1,
        RD_LAST
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CNT_VAL,
        WR_PTR_RDATA,
        WR_IDX_VAL
    } wr_sel_t;

    typedef struct packed {
        logic    idle;
        logic    load;
        logic    exec;
        logic    ptr_ins;
        logic    ptr_rem;
        logic    ptr_dec;
        logic    ptr_inc;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    cap;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        action_t act;
        status_t chk;
        logic    ins_more;
        logic    rem_more;
        logic    out_free;
    } stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/ilir_ctrl.sv
`default_nettype none

module ilir_ctrl
    import ilir_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.chk != ST_OK)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    case (stat.act)
                        ACT_INSERT: state_next = S_INS_RD;
                        ACT_REMOVE: state_next = S_CAP;
                        ACT_READ:   state_next = S_CAP;
                        ACT_POP:    state_next = S_CAP;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_INS_RD:
            begin
                state_next = stat.ins_more ? S_INS_WR : S_DONE;
            end
            S_INS_WR:
            begin
                state_next = S_INS_RD;
            end
            S_CAP:
            begin
                state_next = (stat.act == ACT_REMOVE) ? S_REM_RD : S_DONE;
            end
            S_REM_RD:
            begin
                state_next = stat.rem_more ? S_REM_WR : S_DONE;
            end
            S_REM_WR:
            begin
                state_next = S_REM_RD;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.rd_sel = RD_NONE;
        cmd.wr_sel = WR_NONE;
        case (state_reg)
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                cmd.load = in_valid;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.chk == ST_OK)
                begin
                    case (stat.act)
                        ACT_APPEND:
                        begin
                            cmd.wr_sel  = WR_CNT_VAL;
                            cmd.cnt_inc = 1'b1;
                        end
                        ACT_INSERT:
                        begin
                            cmd.ptr_ins = 1'b1;
                        end
                        ACT_REMOVE:
                        begin
                            cmd.rd_sel  = RD_IDX;
                            cmd.ptr_rem = 1'b1;
                        end
                        ACT_READ:
                        begin
                            cmd.rd_sel = RD_IDX;
                        end
                        ACT_POP:
                        begin
                            cmd.rd_sel = RD_LAST;
                        end
                        default:
                        begin
                            cmd.rd_sel = RD_NONE;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                if (stat.ins_more)
                begin
                    cmd.rd_sel = RD_PTR_M1;
                end
                else
                begin
                    cmd.wr_sel  = WR_IDX_VAL;
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_sel  = WR_PTR_RDATA;
                cmd.ptr_dec = 1'b1;
            end
            S_CAP:
            begin
                cmd.cap     = 1'b1;
                cmd.cnt_dec = (stat.act == ACT_POP);
            end
            S_REM_RD:
            begin
                if (stat.rem_more)
                begin
                    cmd.rd_sel = RD_PTR_P1;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                end
            end
            S_REM_WR:
            begin
                cmd.wr_sel  = WR_PTR_RDATA;
                cmd.ptr_inc = 1'b1;
            end
            S_DONE:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd.idle = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/ilir_dp.sv
`default_nettype none

module ilir_dp
    import ilir_pkg::*;
#(
    parameter int CAPACITY = ILIR_CAPACITY
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output stat_t                   stat,
    input  wire logic [2:0]         action,
    input  wire logic signed [31:0] value,
    input  wire logic [5:0]         index,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      data_out,
    output logic [5:0]              count,
    output logic [1:0]              status
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;

    logic signed [31:0] mem [CAPACITY];

    action_t            act_reg;
    logic signed [31:0] val_reg;
    logic [5:0]         idx_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic [CW-1:0]      ptr_reg;
    logic [CW-1:0]      ptr_next;
    logic signed [31:0] rdata_reg;
    logic signed [31:0] data_reg;
    status_t            status_reg;
    logic               out_valid_reg;
    logic signed [31:0] data_out_reg;
    logic [5:0]         count_reg;
    logic [1:0]         status_out_reg;

    logic [CMPW-1:0]    idx_ext;
    logic [CMPW-1:0]    cnt_ext;
    logic [CMPW-1:0]    ptr_ext;
    logic               is_full;
    status_t            chk;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    assign idx_ext = CMPW'(idx_reg);
    assign cnt_ext = CMPW'(cnt_reg);
    assign ptr_ext = CMPW'(ptr_reg);
    assign is_full = (cnt_reg == CW'(CAPACITY));

    always_comb
    begin
        chk = ST_OK;
        case (act_reg)
            ACT_APPEND:
            begin
                if (is_full)
                begin
                    chk = ST_FULL;
                end
            end
            ACT_INSERT:
            begin
                if (idx_ext > cnt_ext)
                begin
                    chk = ST_BAD;
                end
                else if (is_full)
                begin
                    chk = ST_FULL;
                end
            end
            ACT_REMOVE, ACT_READ:
            begin
                if (idx_ext >= cnt_ext)
                begin
                    chk = ST_BAD;
                end
            end
            ACT_POP:
            begin
                if (cnt_reg == '0)
                begin
                    chk = ST_BAD;
                end
            end
            default:
            begin
                chk = ST_BAD;
            end
        endcase
    end

    assign stat.act      = act_reg;
    assign stat.chk      = chk;
    assign stat.ins_more = (ptr_ext > idx_ext);
    assign stat.rem_more = ((ptr_reg + CW'(1)) < cnt_reg);
    assign stat.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = '0;
        case (cmd.rd_sel)
            RD_IDX:    rd_addr = AW'(idx_reg);
            RD_PTR_M1: rd_addr = AW'(ptr_reg - CW'(1));
            RD_PTR_P1: rd_addr = AW'(ptr_reg + CW'(1));
            RD_LAST:   rd_addr = AW'(cnt_reg - CW'(1));
            default:   rd_en   = 1'b0;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = val_reg;
        case (cmd.wr_sel)
            WR_CNT_VAL:
            begin
                wr_addr = AW'(cnt_reg);
            end
            WR_PTR_RDATA:
            begin
                wr_addr = AW'(ptr_reg);
                wr_data = rdata_reg;
            end
            WR_IDX_VAL:
            begin
                wr_addr = AW'(idx_reg);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.ptr_ins)
        begin
            ptr_next = cnt_reg;
        end
        else if (cmd.ptr_rem)
        begin
            ptr_next = CW'(idx_reg);
        end
        else if (cmd.ptr_dec)
        begin
            ptr_next = ptr_reg - CW'(1);
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.load)
        begin
            act_reg <= action_t'(action);
            val_reg <= value;
            idx_reg <= index;
        end
        if (cmd.exec)
        begin
            status_reg <= chk;
            data_reg   <= '0;
        end
        else if (cmd.cap)
        begin
            data_reg <= rdata_reg;
        end
        if (cmd.out_load)
        begin
            data_out_reg   <= data_reg;
            count_reg      <= 6'(cnt_reg);
            status_out_reg <= status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign count     = count_reg;
    assign status    = status_out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/indexed_list_insert_remove_unit.sv
// Indexed list engine: an ordered list of signed words in a store with one
// read port and one write port.
// Input channel (in_valid/in_stall) carries action, value and index; output
// channel (out_valid/out_stall) returns data_out, count and status, one result
// per accepted item, in order. in_stall is low only while the engine is idle.
// Append, and any rejected action, go straight to the result; read, pop and
// remove first capture a stored word. Insert shifts the count - index entries
// at and above index up by one, remove the count - index - 1 entries above
// index down by one, with count taken before the action. The next item is
// taken in the cycle after the result is registered. Insert and remove move
// one entry at a time, a read state then a write state, through the store's
// one read and one write port.
// A result waits in the output register while out_stall is high; the engine
// holds its finished item until that register can take it.
// Reset empties the list (count 0) and clears out_valid; stored words need
// no clearing since only words below the count are ever read.
`default_nettype none

module indexed_list_insert_remove_unit
    import ilir_pkg::*;
#(
    parameter int CAPACITY = ILIR_CAPACITY
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         action,
    input  wire logic signed [31:0] value,
    input  wire logic [5:0]         index,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      data_out,
    output logic [5:0]              count,
    output logic [1:0]              status
);

    cmd_t  cmd;
    stat_t stat;

    ilir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .cmd      (cmd)
    );

    ilir_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .action    (action),
        .value     (value),
        .index     (index),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .count     (count),
        .status    (status)
    );

    assign in_stall = !cmd.idle;

endmodule

`default_nettype wire
